// ===== src/pixel_to_gimbal_angle_defines.svh =====
// ----------------------------------------------------------------------------
// Pixel to gimbal angle: assertion macros
// Shared check forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_GIMBAL_ANGLE_DEFINES_SVH
`define PIXEL_TO_GIMBAL_ANGLE_DEFINES_SVH

// Same-cycle implication
`define PGA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pga check failed");

// Next-cycle implication
`define PGA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pga check failed");

`endif

// ===== src/pga_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel to gimbal angle package
// Types, register indexes, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package pga_pkg;

    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTRINSIC_A   = 3'd0,
        REG_INTRINSIC_B   = 3'd1,
        REG_INTRINSIC_C   = 3'd2,
        REG_DISTORTION_A  = 3'd3,
        REG_DISTORTION_B  = 3'd4,
        REG_MOUNT_YAW     = 3'd5,
        REG_MOUNT_PITCH   = 3'd6,
        REG_MOUNT_OFFSETS = 3'd7
    } cfg_reg_t;

    typedef logic signed [31:0] q24_t;
    typedef logic signed [63:0] prod_t;

    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 36;   // CORDIC x/y width
    localparam int ZW           = 25;   // CORDIC angle width, degrees Q9.16
    localparam int ANG_W        = 17;
    localparam int BIAS_W       = 13;

    typedef logic signed [CW-1:0]    cxy_t;
    typedef logic signed [ZW-1:0]    cz_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam q24_t ONE_Q24   = 32'sh0100_0000;
    localparam ang_t ANG_LIMIT = 17'sd46080;

    localparam cz_t ATAN_TAB [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115
    };

    localparam logic [11:0] DIST_T0 = 12'd250;
    localparam logic [11:0] DIST_T1 = 12'd300;
    localparam logic [11:0] DIST_T2 = 12'd350;
    localparam logic [11:0] DIST_T3 = 12'd400;
    localparam logic [11:0] DIST_T4 = 12'd460;

    typedef struct packed {
        logic [BIAS_W-1:0] xb;
        logic [BIAS_W-1:0] yb;
    } bias_t;

    function automatic bias_t dist_bias(input logic [11:0] d);
        bias_t b;
        if (d < DIST_T0) begin
            b.xb = 13'd4224; b.yb = 13'd3942;
        end else if (d < DIST_T1) begin
            b.xb = 13'd4480; b.yb = 13'd3942;
        end else if (d < DIST_T2) begin
            b.xb = 13'd4736; b.yb = 13'd3994;
        end else if (d < DIST_T3) begin
            b.xb = 13'd4992; b.yb = 13'd4045;
        end else if (d < DIST_T4) begin
            b.xb = 13'd5248; b.yb = 13'd4096;
        end else begin
            b.xb = 13'd5504; b.yb = 13'd4147;
        end
        return b;
    endfunction

    function automatic q24_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic prod_t mul32(input q24_t a, input q24_t b);
        prod_t r;
        r = a * b;
        return r;
    endfunction

    // Round to nearest, ties up, back to Q8.24
    function automatic q24_t qround(input prod_t p);
        logic signed [64:0] t;
        t = 65'(p) + 65'sd8388608;
        return sat32(64'(t >>> 24));
    endfunction

    function automatic q24_t word_lo(input logic [63:0] r);
        return signed'(r[31:0]);
    endfunction

    function automatic q24_t word_hi(input logic [63:0] r);
        return signed'(r[63:32]);
    endfunction

    function automatic ang_t ang_sat(input logic signed [17:0] v);
        if (v > 18'(ANG_LIMIT))
            return ANG_LIMIT;
        if (v < -18'(ANG_LIMIT))
            return -ANG_LIMIT;
        return v[ANG_W-1:0];
    endfunction

endpackage

// ===== src/pga_pt_if.sv =====
// ----------------------------------------------------------------------------
// Pixel point channel
// Valid/ready channel carrying one image point and target distance.
// ----------------------------------------------------------------------------
interface pga_pt_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [11:0] target_distance;

    modport source (output valid, pixel_x, pixel_y, target_distance, input ready);
    modport sink   (input valid, pixel_x, pixel_y, target_distance, output ready);
endinterface

// ===== src/pga_ang_if.sv =====
// ----------------------------------------------------------------------------
// Gimbal angle channel
// Valid/ready channel carrying one yaw and pitch pair.
// ----------------------------------------------------------------------------
interface pga_ang_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] yaw_angle;
    logic signed [16:0] pitch_angle;

    modport source (output valid, yaw_angle, pitch_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, output ready);
endinterface

// ===== src/pga_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC arctangent
// Vectoring from (1, y), one micro-rotation per register stage, degrees out.
// ----------------------------------------------------------------------------
module pga_cordic
    import pga_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  cxy_t y_in,
    output cz_t  z_out
);

    cxy_t x_reg [CORDIC_STEPS];
    cxy_t y_reg [CORDIC_STEPS];
    cz_t  z_reg [CORDIC_STEPS];

    genvar i;
    for (i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        cxy_t xi;
        cxy_t yi;
        cz_t  zi;

        if (i == 0)
        begin : g_first
            assign xi = CW'(ONE_Q24);
            assign yi = y_in;
            assign zi = '0;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // rotate towards the x axis
                if (yi >= 0)
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - ATAN_TAB[i];
                end
            end
        end
    end

    assign z_out = z_reg[CORDIC_STEPS-1];

endmodule

// ===== src/pixel_to_gimbal_angle.sv =====
// ----------------------------------------------------------------------------
// Pixel to gimbal angle
// Maps a sub-pixel image point through inverse intrinsics, lens distortion
// and a mount transform, then gives yaw and pitch in degrees.
// ----------------------------------------------------------------------------
// Usage:
//   in_pt   : valid/ready, one transaction per point (pixel_x, pixel_y,
//             target_distance). Accepted when valid and ready are high.
//   out_ang : valid/ready, one transaction per point (yaw_angle,
//             pitch_angle, signed Q9.8 degrees, saturated to +-180).
//   cfg_*   : write enable, register index, 64-bit data; write only while
//             no point is in flight.
// From acceptance to the result showing on out_ang a point passes through
// 18 stages of fixed-point arithmetic (multiplies, roundings and sums),
// then a 16-stage CORDIC and one output register.
// Throughput is one point per cycle while out_ang is not stalled; the whole
// pipeline advances together. When the receiver stalls with a result waiting,
// every stage holds and in_pt.ready drops; nothing is lost or repeated.
// Reset clears all coefficient registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`include "pixel_to_gimbal_angle_defines.svh"

module pixel_to_gimbal_angle
    import pga_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pga_pt_if.sink                in_pt,
    pga_ang_if.source             out_ang,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG = 18 + CORDIC_STEPS;

    logic [CFG_DATA_W-1:0] cfg_reg [NUM_REGS];
    logic [NSTG-1:0]       vld_reg;
    logic                  out_vld_reg;
    bias_t                 bias_dly_reg [NSTG];
    logic                  en;

    q24_t a00, a01, a02, a11, a12, k1, k2, k3, p1, p2;
    q24_t m00, m01, m10, m11, off0, off1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
                cfg_reg[r] <= '0;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_idx] <= cfg_data;
        end
    end

    assign a00  = word_lo(cfg_reg[REG_INTRINSIC_A]);
    assign a01  = word_hi(cfg_reg[REG_INTRINSIC_A]);
    assign a02  = word_lo(cfg_reg[REG_INTRINSIC_B]);
    assign a11  = word_hi(cfg_reg[REG_INTRINSIC_B]);
    assign a12  = word_lo(cfg_reg[REG_INTRINSIC_C]);
    assign k1   = word_hi(cfg_reg[REG_INTRINSIC_C]);
    assign k2   = word_lo(cfg_reg[REG_DISTORTION_A]);
    assign k3   = word_hi(cfg_reg[REG_DISTORTION_A]);
    assign p1   = word_lo(cfg_reg[REG_DISTORTION_B]);
    assign p2   = word_hi(cfg_reg[REG_DISTORTION_B]);
    assign m00  = word_lo(cfg_reg[REG_MOUNT_YAW]);
    assign m01  = word_hi(cfg_reg[REG_MOUNT_YAW]);
    assign m10  = word_lo(cfg_reg[REG_MOUNT_PITCH]);
    assign m11  = word_hi(cfg_reg[REG_MOUNT_PITCH]);
    assign off0 = word_lo(cfg_reg[REG_MOUNT_OFFSETS]);
    assign off1 = word_hi(cfg_reg[REG_MOUNT_OFFSETS]);

    // advance when the output register is empty or being taken
    assign en           = !out_vld_reg || out_ang.ready;
    assign in_pt.ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NSTG-2:0], in_pt.valid};
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    // ---------------------------------------------------------------- datapath
    logic signed [48:0] ax_reg, ay_reg, by_reg;
    logic signed [51:0] u_sum_next, v_sum_next;
    q24_t u2_reg, v2_reg;
    prod_t uu_raw_reg, vv_raw_reg, uv_raw_reg;
    q24_t u3_reg, v3_reg;
    q24_t uu4_reg, vv4_reg, uv4_reg, u4_reg, v4_reg;
    q24_t r2_5_reg, uu5_reg, vv5_reg, uv5_reg, u5_reg, v5_reg;
    prod_t r4_raw6_reg, b1_raw6_reg, b2_raw6_reg;
    q24_t qa6_reg, qb6_reg, r2_6_reg, u6_reg, v6_reg;
    prod_t k1r2_raw7_reg, pqa_raw7_reg, pqb_raw7_reg;
    q24_t r4_7_reg, puv1_7_reg, puv2_7_reg, r2_7_reg, u7_reg, v7_reg;
    prod_t r6_raw8_reg, k2r4_raw8_reg;
    q24_t k1r2_8_reg, pqa8_reg, pqb8_reg, puv1_8_reg, puv2_8_reg, u8_reg, v8_reg;
    q24_t r6_9_reg, k2r4_9_reg, k1r2_9_reg, pqa9_reg, pqb9_reg;
    q24_t puv1_9_reg, puv2_9_reg, u9_reg, v9_reg;
    prod_t k3r6_raw10_reg;
    q24_t k1r2_10_reg, k2r4_10_reg, pqa10_reg, pqb10_reg;
    q24_t puv1_10_reg, puv2_10_reg, u10_reg, v10_reg;
    q24_t k3r6_11_reg, k1r2_11_reg, k2r4_11_reg, pqa11_reg, pqb11_reg;
    q24_t puv1_11_reg, puv2_11_reg, u11_reg, v11_reg;
    logic signed [34:0] rad_sum_next;
    q24_t rad12_reg, pqa12_reg, pqb12_reg, puv1_12_reg, puv2_12_reg, u12_reg, v12_reg;
    prod_t urad_raw13_reg, vrad_raw13_reg;
    q24_t pqa13_reg, pqb13_reg, puv1_13_reg, puv2_13_reg;
    q24_t urad14_reg, vrad14_reg, pqa14_reg, pqb14_reg, puv1_14_reg, puv2_14_reg;
    logic signed [34:0] xd_sum_next, yd_sum_next;
    q24_t xd15_reg, yd15_reg;
    prod_t m00_raw16_reg, m01_raw16_reg, m10_raw16_reg, m11_raw16_reg;
    q24_t m00x17_reg, m01y17_reg, m10x17_reg, m11y17_reg;
    logic signed [33:0] h0_sum_next, h1_sum_next;
    cxy_t y_yaw_reg, y_pitch_reg;

    assign u_sum_next = 52'(ax_reg) + 52'(ay_reg) + (52'(a02) <<< 4) + 52'sd8;
    assign v_sum_next = 52'(by_reg) + (52'(a12) <<< 4) + 52'sd8;
    assign rad_sum_next = 35'(ONE_Q24) + 35'(k1r2_11_reg) + 35'(k2r4_11_reg)
                        + 35'(k3r6_11_reg);
    assign xd_sum_next = 35'(urad14_reg) + (35'(puv1_14_reg) <<< 1) + 35'(pqa14_reg);
    assign yd_sum_next = 35'(vrad14_reg) + 35'(pqb14_reg) + (35'(puv2_14_reg) <<< 1);
    assign h0_sum_next = 34'(m00x17_reg) + 34'(m01y17_reg) + 34'(off0);
    assign h1_sum_next = 34'(m10x17_reg) + 34'(m11y17_reg) + 34'(off1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // inverse intrinsics
            ax_reg <= 49'(a00) * 49'($signed({1'b0, in_pt.pixel_x}));
            ay_reg <= 49'(a01) * 49'($signed({1'b0, in_pt.pixel_y}));
            by_reg <= 49'(a11) * 49'($signed({1'b0, in_pt.pixel_y}));
            bias_dly_reg[0] <= dist_bias(in_pt.target_distance);
            for (int s = 1; s < NSTG; s++)
                bias_dly_reg[s] <= bias_dly_reg[s-1];

            u2_reg <= sat32(64'(u_sum_next >>> 4));
            v2_reg <= sat32(64'(v_sum_next >>> 4));

            // squares
            uu_raw_reg <= mul32(u2_reg, u2_reg);
            vv_raw_reg <= mul32(v2_reg, v2_reg);
            uv_raw_reg <= mul32(u2_reg, v2_reg);
            u3_reg <= u2_reg;  v3_reg <= v2_reg;

            uu4_reg <= qround(uu_raw_reg);
            vv4_reg <= qround(vv_raw_reg);
            uv4_reg <= qround(uv_raw_reg);
            u4_reg <= u3_reg;  v4_reg <= v3_reg;

            r2_5_reg <= sat32(64'(uu4_reg) + 64'(vv4_reg));
            uu5_reg <= uu4_reg;  vv5_reg <= vv4_reg;  uv5_reg <= uv4_reg;
            u5_reg <= u4_reg;    v5_reg <= v4_reg;

            r4_raw6_reg <= mul32(r2_5_reg, r2_5_reg);
            b1_raw6_reg <= mul32(p1, uv5_reg);
            b2_raw6_reg <= mul32(p2, uv5_reg);
            qa6_reg <= sat32(64'(r2_5_reg) + (64'(uu5_reg) <<< 1));
            qb6_reg <= sat32(64'(r2_5_reg) + (64'(vv5_reg) <<< 1));
            r2_6_reg <= r2_5_reg;  u6_reg <= u5_reg;  v6_reg <= v5_reg;

            r4_7_reg      <= qround(r4_raw6_reg);
            k1r2_raw7_reg <= mul32(k1, r2_6_reg);
            pqa_raw7_reg  <= mul32(p2, qa6_reg);
            pqb_raw7_reg  <= mul32(p1, qb6_reg);
            puv1_7_reg    <= qround(b1_raw6_reg);
            puv2_7_reg    <= qround(b2_raw6_reg);
            r2_7_reg <= r2_6_reg;  u7_reg <= u6_reg;  v7_reg <= v6_reg;

            // radial powers
            r6_raw8_reg   <= mul32(r4_7_reg, r2_7_reg);
            k2r4_raw8_reg <= mul32(k2, r4_7_reg);
            k1r2_8_reg    <= qround(k1r2_raw7_reg);
            pqa8_reg      <= qround(pqa_raw7_reg);
            pqb8_reg      <= qround(pqb_raw7_reg);
            puv1_8_reg <= puv1_7_reg;  puv2_8_reg <= puv2_7_reg;
            u8_reg <= u7_reg;  v8_reg <= v7_reg;

            r6_9_reg   <= qround(r6_raw8_reg);
            k2r4_9_reg <= qround(k2r4_raw8_reg);
            k1r2_9_reg <= k1r2_8_reg;  pqa9_reg <= pqa8_reg;  pqb9_reg <= pqb8_reg;
            puv1_9_reg <= puv1_8_reg;  puv2_9_reg <= puv2_8_reg;
            u9_reg <= u8_reg;  v9_reg <= v8_reg;

            k3r6_raw10_reg <= mul32(k3, r6_9_reg);
            k1r2_10_reg <= k1r2_9_reg;  k2r4_10_reg <= k2r4_9_reg;
            pqa10_reg <= pqa9_reg;  pqb10_reg <= pqb9_reg;
            puv1_10_reg <= puv1_9_reg;  puv2_10_reg <= puv2_9_reg;
            u10_reg <= u9_reg;  v10_reg <= v9_reg;

            k3r6_11_reg <= qround(k3r6_raw10_reg);
            k1r2_11_reg <= k1r2_10_reg;  k2r4_11_reg <= k2r4_10_reg;
            pqa11_reg <= pqa10_reg;  pqb11_reg <= pqb10_reg;
            puv1_11_reg <= puv1_10_reg;  puv2_11_reg <= puv2_10_reg;
            u11_reg <= u10_reg;  v11_reg <= v10_reg;

            rad12_reg <= sat32(64'(rad_sum_next));
            pqa12_reg <= pqa11_reg;  pqb12_reg <= pqb11_reg;
            puv1_12_reg <= puv1_11_reg;  puv2_12_reg <= puv2_11_reg;
            u12_reg <= u11_reg;  v12_reg <= v11_reg;

            // distorted point
            urad_raw13_reg <= mul32(u12_reg, rad12_reg);
            vrad_raw13_reg <= mul32(v12_reg, rad12_reg);
            pqa13_reg <= pqa12_reg;  pqb13_reg <= pqb12_reg;
            puv1_13_reg <= puv1_12_reg;  puv2_13_reg <= puv2_12_reg;

            urad14_reg <= qround(urad_raw13_reg);
            vrad14_reg <= qround(vrad_raw13_reg);
            pqa14_reg <= pqa13_reg;  pqb14_reg <= pqb13_reg;
            puv1_14_reg <= puv1_13_reg;  puv2_14_reg <= puv2_13_reg;

            xd15_reg <= sat32(64'(xd_sum_next));
            yd15_reg <= sat32(64'(yd_sum_next));

            // mount transform
            m00_raw16_reg <= mul32(m00, xd15_reg);
            m01_raw16_reg <= mul32(m01, yd15_reg);
            m10_raw16_reg <= mul32(m10, xd15_reg);
            m11_raw16_reg <= mul32(m11, yd15_reg);

            m00x17_reg <= qround(m00_raw16_reg);
            m01y17_reg <= qround(m01_raw16_reg);
            m10x17_reg <= qround(m10_raw16_reg);
            m11y17_reg <= qround(m11_raw16_reg);

            // pitch takes atan of the negated value
            y_yaw_reg   <= CW'(sat32(64'(h0_sum_next)));
            y_pitch_reg <= -CW'(sat32(64'(h1_sum_next)));
        end
    end

    cz_t z_yaw, z_pitch;

    pga_cordic u_cordic_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (y_yaw_reg),
        .z_out (z_yaw)
    );

    pga_cordic u_cordic_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (y_pitch_reg),
        .z_out (z_pitch)
    );

    cz_t                zr_yaw_next, zr_pitch_next;
    logic signed [17:0] yaw_next, pitch_next;
    ang_t               yaw_reg, pitch_reg;

    assign zr_yaw_next   = z_yaw + 25'sd128;
    assign zr_pitch_next = z_pitch + 25'sd128;
    assign yaw_next   = 18'(zr_yaw_next >>> 8)
                      - 18'($signed({1'b0, bias_dly_reg[NSTG-1].xb}));
    assign pitch_next = 18'(zr_pitch_next >>> 8)
                      + 18'($signed({1'b0, bias_dly_reg[NSTG-1].yb}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg   <= ang_sat(yaw_next);
            pitch_reg <= ang_sat(pitch_next);
        end
    end

    assign out_ang.valid       = out_vld_reg;
    assign out_ang.yaw_angle   = yaw_reg;
    assign out_ang.pitch_angle = pitch_reg;

    // ---------------------------------------------------------------- checks
    `PGA_ASSERT_IMP(a_accept_has_room, in_pt.valid && in_pt.ready, !out_vld_reg || out_ang.ready)
    `PGA_ASSERT_NXT(a_stall_freezes, !en, $stable(vld_reg) && $stable(out_vld_reg))
    `PGA_ASSERT_NXT(a_result_from_pipe, en && vld_reg[NSTG-1], out_vld_reg)

endmodule
